FILE: rtl/core/smpc_pkg.sv
package smpc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int MOIST_W    = 10;
    localparam int THR_W      = 10;
    localparam int SINCE_W    = 22;
    localparam int TIMER_W    = 16;
    localparam int REASON_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int PROD_W     = 22;
    localparam int DIV_STEPS  = 22;
    localparam int DIV_CNT_W  = 5;

    typedef logic [REASON_W-1:0]  t_reason;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_reason REASON_TIMEOUT_OFF = 3'd0;
    localparam t_reason REASON_AUTO_DRY    = 3'd1;
    localparam t_reason REASON_ON_UNTIL_TO = 3'd2;
    localparam t_reason REASON_SOIL_OK     = 3'd3;
    localparam t_reason REASON_MANUAL_ON   = 3'd4;
    localparam t_reason REASON_MANUAL_OFF  = 3'd5;

    localparam t_cfg_idx CFG_THRESHOLD = 3'd0;
    localparam t_cfg_idx CFG_INTERVAL  = 3'd1;
    localparam t_cfg_idx CFG_TIMEOUT   = 3'd2;
    localparam t_cfg_idx CFG_DRY_RAW   = 3'd3;
    localparam t_cfg_idx CFG_WET_RAW   = 3'd4;

    localparam logic [THR_W-1:0]    THR_MIN      = 10'd10;
    localparam logic [THR_W-1:0]    THR_MAX      = 10'd950;
    localparam logic [THR_W-1:0]    THR_RESET    = 10'd350;
    localparam logic [SINCE_W-1:0]  INTERVAL_MIN = 22'd5000;
    localparam logic [SINCE_W-1:0]  INTERVAL_MAX = 22'd3600000;
    localparam logic [SINCE_W-1:0]  INTERVAL_RST = 22'd15000;
    localparam logic [SINCE_W-1:0]  SINCE_SAT    = 22'h3FFFFF;
    localparam logic [TIMER_W-1:0]  TIMEOUT_MIN  = 16'd1000;
    localparam logic [TIMER_W-1:0]  TIMEOUT_MAX  = 16'd60000;
    localparam logic [TIMER_W-1:0]  TIMEOUT_RST  = 16'd15000;
    localparam logic [SAMPLE_W-1:0] DRY_RST      = 12'd3200;
    localparam logic [SAMPLE_W-1:0] WET_RST      = 12'd1400;
    localparam logic [MOIST_W-1:0]  MOIST_FULL   = 10'd1000;
    localparam logic [MOIST_W-1:0]  SCALE        = 10'd1000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_echo;
        logic [MOIST_W-1:0]  moisture_tenths;
        logic                soil_dry;
        logic                pump_state;
        logic                auto_started;
        logic                pump_changed;
        t_reason             reason_code;
        logic                last_of_run;
    } t_report;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic decide;
        logic sel_b;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic rep_a_valid;
        logic rep_b_valid;
    } t_dp_status;

endpackage

FILE: rtl/core/smpc_in_if.sv
interface smpc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [smpc_pkg::SAMPLE_W-1:0] soil_sample;
    logic                          pump_request;

    modport source (output valid, output action, output soil_sample, output pump_request,
                    input ready);
    modport sink   (input valid, input action, input soil_sample, input pump_request,
                    output ready);
endinterface

FILE: rtl/core/smpc_out_if.sv
interface smpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [smpc_pkg::SAMPLE_W-1:0] sample_echo;
    logic [smpc_pkg::MOIST_W-1:0]  moisture_tenths;
    logic                          soil_dry;
    logic                          pump_state;
    logic                          auto_started;
    logic                          pump_changed;
    smpc_pkg::t_reason             reason_code;
    logic                          last_of_run;

    modport source (output valid, output sample_echo, output moisture_tenths,
                    output soil_dry, output pump_state, output auto_started,
                    output pump_changed, output reason_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input sample_echo, input moisture_tenths,
                    input soil_dry, input pump_state, input auto_started,
                    input pump_changed, input reason_code, input last_of_run,
                    output ready);
endinterface

FILE: rtl/core/smpc_div.sv
module smpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smpc_pkg::PROD_W-1:0]   i_dividend,
    input  logic [smpc_pkg::SAMPLE_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic [smpc_pkg::PROD_W-1:0]   o_quotient
);

    logic [smpc_pkg::PROD_W-1:0]    r_quo;
    logic [smpc_pkg::SAMPLE_W-1:0]  r_rem;
    logic [smpc_pkg::SAMPLE_W-1:0]  r_div;
    logic [smpc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;

    logic [smpc_pkg::SAMPLE_W:0]    trial;
    logic                           q_bit;

    // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
    assign trial = {r_rem, r_quo[smpc_pkg::PROD_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == smpc_pkg::DIV_CNT_W'(smpc_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[smpc_pkg::PROD_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= smpc_pkg::SAMPLE_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[smpc_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/smpc_datapath.sv
module smpc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smpc_pkg::t_dp_cmd               i_cmd,
    output smpc_pkg::t_dp_status            o_status,
    input  logic                            i_action,
    input  logic [smpc_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_req,
    input  logic                            i_cfg_we,
    input  smpc_pkg::t_cfg_idx              i_cfg_index,
    input  logic [smpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output smpc_pkg::t_report               o_report
);

    // Configuration.
    logic [smpc_pkg::THR_W-1:0]    r_thr;
    logic [smpc_pkg::SINCE_W-1:0]  r_interval;
    logic [smpc_pkg::TIMER_W-1:0]  r_timeout;
    logic [smpc_pkg::SAMPLE_W-1:0] r_dry;
    logic [smpc_pkg::SAMPLE_W-1:0] r_wet;

    // Controller state kept across items.
    logic                          r_pump;
    logic [smpc_pkg::TIMER_W-1:0]  r_remain;
    logic [smpc_pkg::SINCE_W-1:0]  r_since;

    // Current item and calibration operands.
    logic                          r_action;
    logic [smpc_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_req;
    logic [smpc_pkg::SAMPLE_W-1:0] r_num;
    logic [smpc_pkg::SAMPLE_W-1:0] r_den;
    logic                          r_zero;
    logic [smpc_pkg::PROD_W-1:0]   r_prod;

    smpc_pkg::t_report             r_rep_a;
    smpc_pkg::t_report             r_rep_b;
    logic                          r_a_valid;
    logic                          r_b_valid;

    logic [smpc_pkg::SAMPLE_W-1:0] n_num;
    logic [smpc_pkg::SAMPLE_W-1:0] n_den;
    logic                          n_zero;

    logic                          div_busy;
    logic [smpc_pkg::PROD_W-1:0]   quotient;

    logic [smpc_pkg::MOIST_W-1:0]  moist;
    logic                          dry;
    logic                          count_down;
    logic [smpc_pkg::TIMER_W-1:0]  remain_dec;
    logic                          timeout;
    logic                          pump_after_to;
    logic [smpc_pkg::SINCE_W-1:0]  since_inc;
    logic                          reading;

    logic                          n_pump;
    logic [smpc_pkg::TIMER_W-1:0]  n_remain;
    logic [smpc_pkg::SINCE_W-1:0]  n_since;
    smpc_pkg::t_report             n_rep_a;
    smpc_pkg::t_report             n_rep_b;
    logic                          n_a_valid;
    logic                          n_b_valid;

    function automatic logic [smpc_pkg::THR_W-1:0] sat_thr(
        input logic [smpc_pkg::THR_W-1:0] v);
        if (v < smpc_pkg::THR_MIN) return smpc_pkg::THR_MIN;
        if (v > smpc_pkg::THR_MAX) return smpc_pkg::THR_MAX;
        return v;
    endfunction

    function automatic logic [smpc_pkg::SINCE_W-1:0] sat_interval(
        input logic [smpc_pkg::SINCE_W-1:0] v);
        if (v < smpc_pkg::INTERVAL_MIN) return smpc_pkg::INTERVAL_MIN;
        if (v > smpc_pkg::INTERVAL_MAX) return smpc_pkg::INTERVAL_MAX;
        return v;
    endfunction

    function automatic logic [smpc_pkg::TIMER_W-1:0] sat_timeout(
        input logic [smpc_pkg::TIMER_W-1:0] v);
        if (v < smpc_pkg::TIMEOUT_MIN) return smpc_pkg::TIMEOUT_MIN;
        if (v > smpc_pkg::TIMEOUT_MAX) return smpc_pkg::TIMEOUT_MAX;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= smpc_pkg::THR_RESET;
            r_interval <= smpc_pkg::INTERVAL_RST;
            r_timeout  <= smpc_pkg::TIMEOUT_RST;
            r_dry      <= smpc_pkg::DRY_RST;
            r_wet      <= smpc_pkg::WET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smpc_pkg::CFG_THRESHOLD: r_thr <= sat_thr(i_cfg_data[smpc_pkg::THR_W-1:0]);
                smpc_pkg::CFG_INTERVAL:  r_interval <= sat_interval(i_cfg_data);
                smpc_pkg::CFG_TIMEOUT:
                    r_timeout <= sat_timeout(i_cfg_data[smpc_pkg::TIMER_W-1:0]);
                smpc_pkg::CFG_DRY_RAW:   r_dry <= i_cfg_data[smpc_pkg::SAMPLE_W-1:0];
                smpc_pkg::CFG_WET_RAW:   r_wet <= i_cfg_data[smpc_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Calibration operands straight from the incoming beat. A sample on the far
    // side of the dry point, or equal calibration points, reads as zero moisture.
    always_comb begin
        n_num  = '0;
        n_den  = '0;
        n_zero = 1'b1;
        if (r_dry > r_wet) begin
            n_zero = (i_sample >= r_dry);
            n_num  = r_dry - i_sample;
            n_den  = r_dry - r_wet;
        end else if (r_wet > r_dry) begin
            n_zero = (i_sample <= r_dry);
            n_num  = i_sample - r_dry;
            n_den  = r_wet - r_dry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sample <= i_sample;
            r_req    <= i_req;
            r_num    <= n_num;
            r_den    <= n_den;
            r_zero   <= n_zero;
        end
        if (i_cmd.mul) begin
            r_prod <= smpc_pkg::PROD_W'(r_num) * smpc_pkg::PROD_W'(smpc_pkg::SCALE);
        end
    end

    smpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_comb begin
        if (r_zero) begin
            moist = '0;
        end else if (quotient > smpc_pkg::PROD_W'(smpc_pkg::MOIST_FULL)) begin
            moist = smpc_pkg::MOIST_FULL;
        end else begin
            moist = quotient[smpc_pkg::MOIST_W-1:0];
        end
        dry = (moist <= r_thr);

        count_down    = r_pump && (r_remain != '0);
        remain_dec    = count_down ? r_remain - 1'b1 : r_remain;
        timeout       = count_down && (remain_dec == '0);
        pump_after_to = r_pump && !timeout;
        since_inc     = (r_since < smpc_pkg::SINCE_SAT) ? r_since + 1'b1 : r_since;
        reading       = (since_inc >= r_interval);

        n_rep_a.sample_echo     = r_sample;
        n_rep_a.moisture_tenths = moist;
        n_rep_a.soil_dry        = dry;
        n_rep_a.pump_state      = 1'b0;
        n_rep_a.auto_started    = 1'b0;
        n_rep_a.pump_changed    = 1'b1;
        n_rep_a.reason_code     = smpc_pkg::REASON_TIMEOUT_OFF;
        n_rep_a.last_of_run     = !reading;

        n_rep_b.sample_echo     = r_sample;
        n_rep_b.moisture_tenths = moist;
        n_rep_b.soil_dry        = dry;
        n_rep_b.pump_state      = pump_after_to;
        n_rep_b.auto_started    = 1'b0;
        n_rep_b.pump_changed    = 1'b0;
        n_rep_b.reason_code     = smpc_pkg::REASON_SOIL_OK;
        n_rep_b.last_of_run     = 1'b1;

        if (r_action) begin
            // A manual command leaves the interval counter alone and reloads or clears the switch-off timer.
            n_pump    = r_req;
            n_remain  = r_req ? r_timeout : '0;
            n_since   = r_since;
            n_a_valid = 1'b0;
            n_b_valid = 1'b1;
            n_rep_b.pump_state   = r_req;
            n_rep_b.pump_changed = 1'b1;
            n_rep_b.reason_code  = r_req ? smpc_pkg::REASON_MANUAL_ON
                                         : smpc_pkg::REASON_MANUAL_OFF;
        end else begin
            n_pump    = pump_after_to;
            n_remain  = remain_dec;
            n_since   = reading ? '0 : since_inc;
            n_a_valid = timeout;
            n_b_valid = reading;
            if (dry) begin
                n_rep_b.reason_code = smpc_pkg::REASON_AUTO_DRY;
                if (!pump_after_to && reading) begin
                    n_pump                = 1'b1;
                    n_remain              = r_timeout;
                    n_rep_b.pump_state    = 1'b1;
                    n_rep_b.auto_started  = 1'b1;
                    n_rep_b.pump_changed  = 1'b1;
                end
            end else if (pump_after_to) begin
                n_rep_b.reason_code = smpc_pkg::REASON_ON_UNTIL_TO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump    <= 1'b0;
            r_remain  <= '0;
            r_since   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_pump    <= n_pump;
            r_remain  <= n_remain;
            r_since   <= n_since;
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_rep_a <= n_rep_a;
            r_rep_b <= n_rep_b;
        end
    end

    assign o_status.div_busy    = div_busy;
    assign o_status.rep_a_valid = r_a_valid;
    assign o_status.rep_b_valid = r_b_valid;
    assign o_report             = i_cmd.sel_b ? r_rep_b : r_rep_a;

endmodule

FILE: rtl/core/smpc_ctrl.sv
module smpc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  smpc_pkg::t_dp_status i_status,
    output smpc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_DECIDE,
        S_ROUTE,
        S_EMIT_A,
        S_EMIT_B
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   r_sel_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL:    n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV:    if (!i_status.div_busy) n_state = S_DECIDE;
            S_DECIDE: n_state = S_ROUTE;
            S_ROUTE: begin
                if (i_status.rep_a_valid) begin
                    n_state = S_EMIT_A;
                end else if (i_status.rep_b_valid) begin
                    n_state = S_EMIT_B;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_A: begin
                if (i_out_ready) begin
                    n_state = i_status.rep_b_valid ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B: if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_sel_b     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_EMIT_A) || (n_state == S_EMIT_B);
            r_sel_b     <= (n_state == S_EMIT_B);
        end
    end

    assign o_in_ready      = r_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cmd.load      = i_in_valid && r_in_ready;
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.div_start = (r_state == S_START);
    assign o_cmd.decide    = (r_state == S_DECIDE);
    assign o_cmd.sel_b     = r_sel_b;

endmodule

FILE: rtl/core/soil_moisture_pump_controller.sv
// Soil moisture pump controller.
// Input channel i_in: one beat is either a millisecond tick with the current ADC
// sample (action 0) or a manual pump command (action 1). Output channel o_out
// carries reports; an input beat yields zero, one or two of them, and the last
// one of an item has last_of_run set. A tick that neither times out the pump nor
// completes a reading interval produces no report.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, one
// register per cycle; the user must write it only while no item is in flight,
// which the block does not enforce. Out-of-range values are saturated
// (the threshold and timeout after truncation to their widths) and unknown
// indexes are ignored.
// Items are processed one at a time. An accepted beat passes through a multiply
// state, a divider load state, the bit-serial restoring divider and a state
// that sees it finish, then a decision state and a routing state before the
// first report is offered; a second one follows when the first is taken, and
// i_in.ready returns the cycle after the last report is taken. A stall on o_out
// simply holds the current report and keeps i_in.ready low.
// Reset restores the default configuration, switches the pump off, clears the
// switch-off countdown and the interval counter.
module soil_moisture_pump_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    smpc_in_if.sink                         i_in,
    smpc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [smpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [smpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    smpc_pkg::t_dp_cmd    cmd;
    smpc_pkg::t_dp_status status;
    smpc_pkg::t_report    report;

    smpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    smpc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_action    (i_in.action),
        .i_sample    (i_in.soil_sample),
        .i_req       (i_in.pump_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_report    (report)
    );

    assign o_out.sample_echo     = report.sample_echo;
    assign o_out.moisture_tenths = report.moisture_tenths;
    assign o_out.soil_dry        = report.soil_dry;
    assign o_out.pump_state      = report.pump_state;
    assign o_out.auto_started    = report.auto_started;
    assign o_out.pump_changed    = report.pump_changed;
    assign o_out.reason_code     = report.reason_code;
    assign o_out.last_of_run     = report.last_of_run;

    // The block never takes a new item while a report is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a report is pending");

    // Once the final report of an item is taken, nothing more is offered.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run) |=> !o_out.valid)
        else $error("report offered after the last of a run");

    // An accepted beat keeps the input side closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after an accepted beat");

    // A timeout report always shows the pump switched off.
    a_timeout_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.reason_code == smpc_pkg::REASON_TIMEOUT_OFF)
            |-> (!o_out.pump_state && o_out.pump_changed))
        else $error("timeout report with pump still on");

endmodule
